[design/mvk_pkg.sv]
`timescale 1ns / 1ps

package mvk_pkg;

  // Field widths
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned KEY_TOTAL = 6;
  localparam int unsigned KEY_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [KEY_W-1:0] NO_KEY = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 1'b1;

  // Reciprocals scaled by 2^16; exact floor for the operand ranges used
  localparam logic [12:0] RECIP9  = 13'd7282;
  localparam logic [12:0] RECIP12 = 13'd5462;
  localparam logic [14:0] RECIP3  = 15'd21846;

  typedef enum logic [1:0] {
    OP_DOWN   = 2'd0,
    OP_MOTION = 2'd1,
    OP_UP     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CELL,
    ST_HIT,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic load;
    logic div;
    logic geom;
    logic hit;
    logic apply;
  } ctrl_cmd_t;

endpackage

[design/multitouch_virtual_key_mapper_core.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// event    in         start & !busy           operation_i, finger_id_i, touch_x_i, touch_y_i
// result   out        done_o (one-cycle word) keys_down_o, event_applied_o
// config   in         cfg_we_i                cfg_idx_i (0 width, 1 height), cfg_wdata_i
//
// Each event word passes through the work steps: cell divisions, cell/margin/side,
// rectangle hit test with slot search, then the table update. The controller
// sequences these one after another; busy is high while they run. The result word
// is strobed on done_o in the cycle after the update, while a new event word may
// already be accepted. Reset clears the slot table and window size.
// The receiver cannot stall: take the result word in the cycle it is shown.

module multitouch_virtual_key_mapper_core import mvk_pkg::*; #(
  parameter int unsigned FINGER_SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [ID_W-1:0]      finger_id_i,
  input  logic [COORD_W-1:0]   touch_x_i,
  input  logic [COORD_W-1:0]   touch_y_i,
  output logic [KEY_TOTAL-1:0] keys_down_o,
  output logic                 event_applied_o,
  output logic                 done_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i
);

  ctrl_cmd_t        cmd;
  logic             win_ok;
  logic [KEY_W-1:0] key;

  // Sequence the four work steps of each accepted word
  mvk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Hold the window size and work out which key the touch falls on
  mvk_layout u_layout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .touch_x_i   (touch_x_i),
    .touch_y_i   (touch_y_i),
    .win_ok_o    (win_ok),
    .key_o       (key)
  );

  // Keep the finger slots, apply the event and drive the result word
  mvk_slots #(
    .FINGER_SLOTS (FINGER_SLOTS)
  ) u_slots (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (operation_i),
    .finger_id_i     (finger_id_i),
    .win_ok_i        (win_ok),
    .key_i           (key),
    .keys_down_o     (keys_down_o),
    .event_applied_o (event_applied_o),
    .done_o          (done_o)
  );

endmodule

[design/mvk_ctrl.sv]
`timescale 1ns / 1ps

module mvk_ctrl import mvk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_CELL;
      end
      ST_CELL: begin
        cmd_o.geom = 1'b1;
        state_d    = ST_HIT;
      end
      ST_HIT: begin
        cmd_o.hit = 1'b1;
        state_d   = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  a_start_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_DIV))
    else $error("accepted word did not enter the sequence");

  a_apply_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> !busy)
    else $error("sequence did not return to idle after apply");

endmodule

[design/mvk_layout.sv]
`timescale 1ns / 1ps

module mvk_layout import mvk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i,
  input  logic [COORD_W-1:0]   touch_x_i,
  input  logic [COORD_W-1:0]   touch_y_i,
  output logic                 win_ok_o,
  output logic [KEY_W-1:0]     key_o
);

  localparam int unsigned CW = COORD_W + 1;

  logic [COORD_W-1:0] width_q, height_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [8:0]         q9_q, q12_q;
  logic [8:0]         cell_q;
  logic [7:0]         margin_q;
  logic [9:0]         side_q;
  logic [KEY_W-1:0]   key_q;

  logic [COORD_W-1:0] min_wh;
  logic [24:0]        prod9, prod12;
  logic [8:0]         cell_d;
  logic [23:0]        prod3;
  logic [KEY_W-1:0]   key_d;

  logic [CW-1:0] c, m, s, w, h, top, x13, y13;
  logic [CW-1:0] bx [KEY_TOTAL];
  logic [CW-1:0] by [KEY_TOTAL];
  logic [CW-1:0] bs [KEY_TOTAL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH_IDX:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT_IDX: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign win_ok_o = (|width_q) && (|height_q);

  // Cell candidates: min(w,h)/9 and h/12
  assign min_wh = (width_q < height_q) ? width_q : height_q;
  assign prod9  = 25'(min_wh) * 25'(RECIP9);
  assign prod12 = 25'(height_q) * 25'(RECIP12);

  // Cell, margin = cell/3, side = cell + cell/2
  assign cell_d = (q9_q < q12_q) ? q9_q : q12_q;
  assign prod3  = 24'(cell_d) * 24'(RECIP3);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= touch_x_i;
      y_q <= touch_y_i;
    end
    if (cmd_i.div) begin
      q9_q  <= prod9[24:16];
      q12_q <= prod12[24:16];
    end
    if (cmd_i.geom) begin
      cell_q   <= cell_d;
      margin_q <= prod3[23:16];
      side_q   <= 10'(cell_d) + 10'(cell_d >> 1);
    end
    if (cmd_i.hit) begin
      key_q <= key_d;
    end
  end

  // Key rectangles; every coordinate stays non-negative
  always_comb begin
    c   = CW'(cell_q);
    m   = CW'(margin_q);
    s   = CW'(side_q);
    w   = CW'(width_q);
    h   = CW'(height_q);
    x13 = CW'(x_q);
    y13 = CW'(y_q);
    top = h - m - (c + (c << 1));

    bx[0] = m;           by[0] = top + c;        bs[0] = c;
    bx[1] = m + (c << 1); by[1] = top + c;       bs[1] = c;
    bx[2] = m + c;       by[2] = top;            bs[2] = c;
    bx[3] = m + c;       by[3] = top + (c << 1); bs[3] = c;
    bx[4] = w - m - s;   by[4] = h - m - s;      bs[4] = s;
    bx[5] = w - m - c;   by[5] = m;              bs[5] = c;

    // First key in bit order wins where rectangles overlap
    key_d = NO_KEY;
    for (int k = KEY_TOTAL - 1; k >= 0; k--) begin
      if (x13 >= bx[k] && x13 < bx[k] + bs[k] &&
          y13 >= by[k] && y13 < by[k] + bs[k]) begin
        key_d = KEY_W'(k);
      end
    end
  end

  assign key_o = key_q;

endmodule

[design/mvk_slots.sv]
`timescale 1ns / 1ps

module mvk_slots import mvk_pkg::*; #(
  parameter int unsigned FINGER_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  input  logic [1:0]          operation_i,
  input  logic [ID_W-1:0]     finger_id_i,
  input  logic                win_ok_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic [KEY_TOTAL-1:0] keys_down_o,
  output logic                event_applied_o,
  output logic                done_o
);

  localparam int unsigned SLOT_IDX_W = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

  typedef logic [KEY_W-1:0] key_arr_t [FINGER_SLOTS];

  logic [FINGER_SLOTS-1:0] used_q, used_d;
  key_arr_t                key_q, key_d;
  logic [ID_W-1:0]         finger_q [FINGER_SLOTS];

  logic [1:0]              op_q;
  logic [ID_W-1:0]         id_q;
  logic                    tgt_found_q;
  logic [SLOT_IDX_W-1:0]   tgt_idx_q;

  logic                    free_found, match_found;
  logic [SLOT_IDX_W-1:0]   free_idx, match_idx;
  logic                    op_valid, commit;
  logic [KEY_TOTAL-1:0]    map_d, map_now;

  logic [KEY_TOTAL-1:0]    keys_down_q;
  logic                    applied_q, done_q;

  function automatic logic [KEY_TOTAL-1:0] key_map(logic [FINGER_SLOTS-1:0] used,
                                                   key_arr_t keys);
    logic [KEY_TOTAL-1:0] acc;
    acc = '0;
    for (int i = 0; i < FINGER_SLOTS; i++) begin
      if (used[i] && keys[i] < KEY_W'(KEY_TOTAL)) begin
        acc[keys[i]] = 1'b1;
      end
    end
    return acc;
  endfunction

  // Lowest free slot and lowest matching used slot
  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = FINGER_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
      if (used_q[i] && finger_q[i] == id_q) begin
        match_found = 1'b1;
        match_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign op_valid = op_q inside {OP_DOWN, OP_MOTION, OP_UP};
  assign commit   = cmd_i.apply && win_ok_i && op_valid && tgt_found_q;

  always_comb begin
    used_d = used_q;
    key_d  = key_q;
    if (commit) begin
      case (op_q)
        OP_DOWN: begin
          used_d[tgt_idx_q] = 1'b1;
          key_d[tgt_idx_q]  = key_i;
        end
        OP_MOTION: begin
          key_d[tgt_idx_q] = key_i;
        end
        OP_UP: begin
          used_d[tgt_idx_q] = 1'b0;
          key_d[tgt_idx_q]  = NO_KEY;
        end
        default: ;
      endcase
    end
  end

  assign map_d   = key_map(used_d, key_d);
  assign map_now = key_map(used_q, key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      tgt_found_q <= 1'b0;
      done_q      <= 1'b0;
      for (int i = 0; i < FINGER_SLOTS; i++) begin
        key_q[i] <= NO_KEY;
      end
    end else begin
      used_q <= used_d;
      key_q  <= key_d;
      done_q <= cmd_i.apply;
      if (cmd_i.hit) begin
        tgt_found_q <= (op_q == OP_DOWN) ? free_found : match_found;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      id_q <= finger_id_i;
    end
    if (cmd_i.hit) begin
      tgt_idx_q <= (op_q == OP_DOWN) ? free_idx : match_idx;
    end
    if (commit && op_q == OP_DOWN) begin
      finger_q[tgt_idx_q] <= id_q;
    end
    if (cmd_i.apply) begin
      keys_down_q <= map_d;
      applied_q   <= commit;
    end
  end

  assign keys_down_o     = keys_down_q;
  assign event_applied_o = applied_q;
  assign done_o          = done_q;

  a_map_matches_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (keys_down_q == map_now))
    else $error("result word disagrees with slot table");

  a_down_takes_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == OP_DOWN) |=>
      ($countones(used_q) == $past($countones(used_q)) + 1))
    else $error("applied down did not occupy one slot");

  a_up_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == OP_UP) |=>
      ($countones(used_q) + 1 == $past($countones(used_q))))
    else $error("applied up did not free one slot");

endmodule
